### rtl/fmr_pkg.sv
// fmr_pkg: shared widths, constants, codes and types of the frame rate meter.
// Used by every module of the block; no dependencies.
package fmr_pkg;

   localparam int STAMP_W       = 32;
   localparam int DRAW_W        = 20;
   localparam int RATE_W        = 24;
   localparam int WIN_DEPTH_DEF = 256;

   // rate = (count-1) * 1000 * 256 / span, scale fits in 18 bits
   localparam int RATE_SCALE    = 256000;
   localparam int RATE_SCALE_W  = 18;

   localparam logic [STAMP_W-1:0] SPAN_MIN_MS   = 32'd1000;
   localparam logic [STAMP_W-1:0] WINDOW_RESET  = 32'd1000;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_WINDOW_IDX = 1'b0;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP,
      ST_PUSH,
      ST_PRUNE_RD,
      ST_PRUNE,
      ST_RATE_GO,
      ST_RATE_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_OUT
   } fmr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fmr_div_stat_type;

endpackage

### rtl/sliding_window_frame_rate_meter.sv
// sliding_window_frame_rate_meter: top level, sequencer, window bookkeeping, csr.
// Depends on fmr_pkg, fmr_ram (stamp and draw stores) and fmr_div.
//
// Usage: each req item is either a record (op 0: timestamp and draw time) or a
// clear (op 1). Every item yields exactly one rsp item with the cached rate in
// Q16.8, the newest and mean draw time, the held frame count and an empty flag.
// Timestamps and draw times sit in two RAMs used as a circular window; a record
// drops the oldest entry when full, pushes, then pops entries older than
// timestamp - window_ms from the front, one RAM read per pop.
// A clear goes straight to the output. Two divisions (rate and mean) share one
// bit-serial divider of DIV_W bits (29 at depth 256), and each pop costs a RAM
// read and a compare. When the rate is held the rate division is skipped.
// One item is worked on at a time; req_ready is high only when idle.
// The result sits in an output register: a stalled receiver holds it, and the
// next item is taken and worked on meanwhile, stalling only at delivery.
// Reset clears the window, the rate and window_ms (back to 1000 ms); RAM
// contents need no clearing since only written entries are read.
// window_ms is written through the APB port at byte address 0; write it only
// while idle. The block itself does not enforce this.
module sliding_window_frame_rate_meter import fmr_pkg::*; #(
   parameter int WINDOW_DEPTH = WIN_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [STAMP_W-1:0]                  req_timestamp_ms,
   input  logic [DRAW_W-1:0]                   req_draw_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [RATE_W-1:0]                   rsp_fps_q8,
   output logic [DRAW_W-1:0]                   rsp_last_draw,
   output logic [DRAW_W-1:0]                   rsp_avg_draw,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]   rsp_frame_count,
   output logic                                rsp_window_empty,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [CSR_ADDR_W-1:0]               paddr,
   input  logic [CSR_DATA_W-1:0]               pwdata,
   output logic [CSR_DATA_W-1:0]               prdata,
   output logic                                pready
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = DRAW_W + CNT_W;
   localparam int NUM_W = CNT_W + RATE_SCALE_W;
   localparam int DIV_W = (SUM_W > RATE_W) ? SUM_W : RATE_W + 1;

   // csr
   logic [STAMP_W-1:0] window_ff, window_in;

   always_comb begin
      window_in = window_ff;
      if (psel && penable && pwrite && pready && paddr[2] == CSR_WINDOW_IDX) begin
         window_in = pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_WINDOW_IDX) ? window_ff : '0;

   // sequencer and window state
   fmr_state_type state_ff, state_in;

   logic               op_ff, op_in;
   logic [STAMP_W-1:0] ts_ff, ts_in;
   logic [DRAW_W-1:0]  dt_ff, dt_in;
   logic               prune_en_ff, prune_en_in;
   logic [STAMP_W-1:0] cutoff_ff, cutoff_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [DRAW_W-1:0]  last_ff, last_in;
   logic [DRAW_W-1:0]  avg_ff, avg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_fps_ff, rsp_fps_in;
   logic [DRAW_W-1:0]  rsp_last_ff, rsp_last_in;
   logic [DRAW_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;

   // memory and divider hookup
   logic               ram_rd_en;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   push_slot;
   logic [STAMP_W-1:0] stamp_rd;
   logic [DRAW_W-1:0]  draw_rd;

   logic               div_start;
   logic               div_sel_avg;
   logic [DIV_W-1:0]   div_dividend;
   logic [STAMP_W-1:0] div_divisor;
   fmr_div_stat_type   div_stat;
   logic [DIV_W-1:0]   div_quotient;

   logic               accept;
   logic               out_load;
   logic               window_full;
   logic               pop;
   logic               rate_ok;
   logic [STAMP_W-1:0] span;
   logic [CNT_W:0]     slot_sum;
   logic [PTR_W-1:0]   head_inc;
   logic [NUM_W-1:0]   rate_num;

   always_comb begin
      accept      = req_valid && req_ready;
      window_full = (count_ff == CNT_W'(WINDOW_DEPTH));
      slot_sum    = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      if (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
         slot_sum = slot_sum - (CNT_W+1)'(WINDOW_DEPTH);
      end
      push_slot = slot_sum[PTR_W-1:0];
      head_inc  = (head_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      // the newest entry never leaves: count stays at least one
      pop       = prune_en_ff && (count_ff > CNT_W'(1)) && (stamp_rd < cutoff_ff);
      span      = ts_ff - oldest_ff;
      rate_ok   = (count_ff >= CNT_W'(2)) && (ts_ff >= oldest_ff) && (span >= SPAN_MIN_MS);
      rate_num  = NUM_W'(count_ff - CNT_W'(1)) * NUM_W'(RATE_SCALE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_CLEAR) begin
                  state_in = ST_OUT;
               end else if (window_full) begin
                  state_in = ST_DROP_RD;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_DROP_RD:  state_in = ST_DROP;
         ST_DROP:     state_in = ST_PUSH;
         ST_PUSH:     state_in = ST_PRUNE_RD;
         ST_PRUNE_RD: state_in = ST_PRUNE;
         ST_PRUNE: begin
            state_in = pop ? ST_PRUNE_RD : ST_RATE_GO;
         end
         ST_RATE_GO: begin
            state_in = rate_ok ? ST_RATE_WAIT : ST_AVG_GO;
         end
         ST_RATE_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      div_start   = 1'b0;
      div_sel_avg = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_DROP_RD:  ram_rd_en = 1'b1;
         ST_PUSH:     ram_wr_en = 1'b1;
         ST_PRUNE_RD: ram_rd_en = 1'b1;
         ST_RATE_GO:  div_start = rate_ok;
         ST_AVG_GO: begin
            div_start   = 1'b1;
            div_sel_avg = 1'b1;
         end
         ST_OUT:      out_load = ~rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign div_dividend = div_sel_avg ? DIV_W'(sum_ff) : DIV_W'(rate_num);
   assign div_divisor  = div_sel_avg ? STAMP_W'(count_ff) : span;

   // window bookkeeping
   always_comb begin
      op_in        = op_ff;
      ts_in        = ts_ff;
      dt_in        = dt_ff;
      prune_en_in  = prune_en_ff;
      cutoff_in    = cutoff_ff;
      oldest_in    = oldest_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rate_in      = rate_ff;
      last_in      = last_ff;
      avg_in       = avg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               ts_in       = req_timestamp_ms;
               dt_in       = req_draw_time;
               // window longer than the timestamp: nothing is pruned
               prune_en_in = (req_timestamp_ms >= window_ff);
               cutoff_in   = req_timestamp_ms - window_ff;
               if (req_op == OP_CLEAR) begin
                  head_in  = '0;
                  count_in = '0;
                  sum_in   = '0;
                  rate_in  = '0;
                  last_in  = '0;
                  avg_in   = '0;
               end
            end
         end
         ST_DROP: begin
            sum_in   = sum_ff - SUM_W'(draw_rd);
            head_in  = head_inc;
            count_in = count_ff - CNT_W'(1);
         end
         ST_PUSH: begin
            sum_in   = sum_ff + SUM_W'(dt_ff);
            count_in = count_ff + CNT_W'(1);
            last_in  = dt_ff;
         end
         ST_PRUNE: begin
            if (pop) begin
               sum_in   = sum_ff - SUM_W'(draw_rd);
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end else begin
               oldest_in = stamp_rd;
            end
         end
         ST_RATE_WAIT: begin
            if (div_stat.done) begin
               rate_in = (|div_quotient[DIV_W-1:RATE_W]) ? '1 : div_quotient[RATE_W-1:0];
            end
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               // mean never exceeds the largest draw time
               avg_in = div_quotient[DRAW_W-1:0];
            end
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && ~rsp_ready;
      rsp_fps_in   = rsp_fps_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_fps_in   = rate_ff;
         rsp_last_in  = last_ff;
         rsp_avg_in   = avg_ff;
         rsp_count_in = count_ff;
         rsp_empty_in = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ts_ff        <= ts_in;
      dt_ff        <= dt_in;
      prune_en_ff  <= prune_en_in;
      cutoff_ff    <= cutoff_in;
      oldest_ff    <= oldest_in;
      last_ff      <= last_in;
      avg_ff       <= avg_in;
      rsp_fps_ff   <= rsp_fps_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fps_q8       = rsp_fps_ff;
   assign rsp_last_draw    = rsp_last_ff;
   assign rsp_avg_draw     = rsp_avg_ff;
   assign rsp_frame_count  = rsp_count_ff;
   assign rsp_window_empty = rsp_empty_ff;

   fmr_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (push_slot),
      .wr_data (ts_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (stamp_rd)
   );

   fmr_ram #(
      .WIDTH (DRAW_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_draw_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (push_slot),
      .wr_data (dt_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (draw_rd)
   );

   fmr_div #(
      .DVD_W (DIV_W),
      .DVS_W (STAMP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window count above depth");

   a_prune_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRUNE) |-> (count_ff != '0))
      else $error("pruning an empty window");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == '0)))
      else $error("empty flag disagrees with frame count");

   a_record_nonempty: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == OP_RECORD) |=> !rsp_empty_ff)
      else $error("record item left the window empty");
`endif

endmodule

### rtl/fmr_ram.sv
// fmr_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on fmr_pkg only through the common import.
module fmr_ram import fmr_pkg::*; #(
   parameter int WIDTH = DRAW_W,
   parameter int DEPTH = WIN_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fmr_div.sv
// fmr_div: restoring divider, one quotient bit per cycle.
// Depends on fmr_pkg for the status struct.
module fmr_div import fmr_pkg::*; #(
   parameter int DVD_W = 29,
   parameter int DVS_W = STAMP_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output fmr_div_stat_type stat,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0] shifted;
   logic [DVS_W:0] diff;
   logic           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = ~diff[DVS_W];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
